// ===== hdl/uarttq_pkg.sv =====
package uarttq_pkg;

    // Stream widths, whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Line and timing constants
    localparam logic [15:0] CPB_RESET     = 16'd16;
    localparam int          QUEUE_DEPTH_D = 16;
    localparam logic [3:0]  STOP_SLOT     = 4'd9;
    localparam logic [3:0]  LAST_DATA_BIT = 4'd8;
    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [7:0]  CH_LF         = 8'h0A;

    // Outcome of one tick, before it is split into beats
    typedef struct packed {
        logic       txd;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       push_dropped;
        logic       two_beats;
    } tick_res_t;

endpackage

// ===== hdl/uart_transceiver_with_tx_queue.sv =====
// An accepted tick's result beat is registered in the output stage, or in the
// skid stage while the output stalls. One tick per cycle while the skid is empty;
// a CR or LF tick yields two beats, so the next tick waits in the skid and the input stalls.
// Reset (synchronous, aresetn low): both serial engines idle, lines high, queue
// empty, clocks_per_bit back to 16; queue contents are left as they are.
module uart_transceiver_with_tx_queue
    import uarttq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,   // clocks_per_bit
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // rxd, tx_push, tx_byte[7:0], zeros
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // txd, rx_valid, rx_byte[7:0], push_dropped, zeros
    output logic                 m_tlast
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [15:0] cpb_reg;

    logic        rx_busy_reg,  rx_busy_next;
    logic [15:0] rx_cnt_reg,   rx_cnt_next;
    logic [3:0]  rx_idx_reg,   rx_idx_next;
    logic        rx_prev_reg;
    logic [7:0]  rx_shift_reg, rx_shift_next;

    logic        tx_busy_reg,  tx_busy_next;
    logic [15:0] tx_cnt_reg,   tx_cnt_next;
    logic [3:0]  tx_idx_reg,   tx_idx_next;
    logic        tx_line_reg,  tx_line_next;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;

    logic        rxd, tx_push;
    logic [7:0]  tx_byte;
    logic        accept;
    logic [15:0] reload;
    logic        rx_emit;
    logic [2:0]  rx_sel;
    logic        q_full;
    logic        q_write;
    logic [7:0]  q_rd_data;
    logic        out_ready;
    tick_res_t   res;

    assign rxd     = s_tdata[0];
    assign tx_push = s_tdata[1];
    assign tx_byte = s_tdata[9:2];
    assign accept  = s_tvalid && s_tready;
    assign s_tready = out_ready;
    assign reload  = cpb_reg - 16'd1;

    // Receive: edge detect, mid-bit sampling, emit at the stop slot
    always_comb begin
        rx_busy_next  = rx_busy_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_idx_next   = rx_idx_reg;
        rx_shift_next = rx_shift_reg;
        rx_emit       = 1'b0;
        rx_sel        = 3'(rx_idx_reg - 4'd1);
        if (!rx_busy_reg) begin
            if (!rxd && rx_prev_reg) begin
                rx_busy_next  = 1'b1;
                rx_cnt_next   = {1'b0, cpb_reg[15:1]};
                rx_idx_next   = 4'd0;
                rx_shift_next = 8'd0;
            end
        end else if (rx_cnt_reg == 16'd0) begin
            if (rx_idx_reg == STOP_SLOT) begin
                rx_emit      = 1'b1;
                rx_busy_next = 1'b0;
            end else if (rx_idx_reg >= 4'd1 && rx_idx_reg <= LAST_DATA_BIT) begin
                rx_shift_next[rx_sel] = rx_shift_reg[rx_sel] | rxd;
            end
            rx_cnt_next = reload;
            rx_idx_next = rx_idx_reg + 4'd1;
        end else begin
            rx_cnt_next = rx_cnt_reg - 16'd1;
        end
    end

    // Transmit: start, eight data bits, stop; pop as the stop bit begins
    always_comb begin
        tx_busy_next = tx_busy_reg;
        tx_cnt_next  = tx_cnt_reg;
        tx_idx_next  = tx_idx_reg;
        tx_line_next = tx_line_reg;
        rd_ptr_next  = rd_ptr_reg;
        if (!tx_busy_reg) begin
            if (rd_ptr_reg != wr_ptr_reg) begin
                tx_busy_next = 1'b1;
                tx_cnt_next  = reload;
                tx_idx_next  = 4'd0;
                tx_line_next = 1'b0;
            end else begin
                tx_line_next = 1'b1;
            end
        end else if (tx_cnt_reg == 16'd0) begin
            if (tx_idx_reg < LAST_DATA_BIT) begin
                tx_line_next = q_rd_data[tx_idx_reg[2:0]];
            end else if (tx_idx_reg == LAST_DATA_BIT) begin
                tx_line_next = 1'b1;
                rd_ptr_next  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end else begin
                tx_busy_next = 1'b0;
            end
            tx_cnt_next = reload;
            tx_idx_next = tx_idx_reg + 4'd1;
        end else begin
            tx_cnt_next = tx_cnt_reg - 16'd1;
        end
    end

    // Push after the transmit update; drop when one slot short of wrapping
    assign wr_ptr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign q_full      = (wr_ptr_inc == rd_ptr_next);
    assign q_write     = accept && tx_push && !q_full;
    assign wr_ptr_next = q_write ? wr_ptr_inc : wr_ptr_reg;

    // Tick result
    always_comb begin
        res.txd          = tx_line_next;
        res.rx_valid     = rx_emit;
        res.rx_byte      = rx_emit ? rx_shift_reg : 8'd0;
        res.push_dropped = tx_push && q_full;
        res.two_beats    = rx_emit && (rx_shift_reg == CH_CR || rx_shift_reg == CH_LF);
    end

    // Hold engine and queue state; advance only on an accepted beat; cfg_we writes clocks_per_bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpb_reg      <= CPB_RESET;
            rx_busy_reg  <= 1'b0;
            rx_cnt_reg   <= '0;
            rx_idx_reg   <= '0;
            rx_prev_reg  <= 1'b1;
            rx_shift_reg <= '0;
            tx_busy_reg  <= 1'b0;
            tx_cnt_reg   <= '0;
            tx_idx_reg   <= '0;
            tx_line_reg  <= 1'b1;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
        end else begin
            if (cfg_we) begin
                cpb_reg <= cfg_wdata;
            end
            if (accept) begin
                rx_busy_reg  <= rx_busy_next;
                rx_cnt_reg   <= rx_cnt_next;
                rx_idx_reg   <= rx_idx_next;
                rx_prev_reg  <= rxd;
                rx_shift_reg <= rx_shift_next;
                tx_busy_reg  <= tx_busy_next;
                tx_cnt_reg   <= tx_cnt_next;
                tx_idx_reg   <= tx_idx_next;
                tx_line_reg  <= tx_line_next;
                rd_ptr_reg   <= rd_ptr_next;
                wr_ptr_reg   <= wr_ptr_next;
            end
        end
    end

    // Transmit queue storage; head entry read every cycle
    uarttq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (q_write),
        .wr_addr (wr_ptr_reg),
        .wr_data (tx_byte),
        .rd_addr (rd_ptr_reg),
        .rd_data (q_rd_data)
    );

    uarttq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (out_ready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/uarttq_ram.sv =====
module uarttq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/uarttq_out.sv =====
module uarttq_out
    import uarttq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tick_res_t            in_res,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // txd, rx_valid, rx_byte[7:0], push_dropped, zeros
    output logic                 m_tlast
);

    tick_res_t out_reg;
    tick_res_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      phase_reg;
    logic      load_out;
    logic      in_take;
    logic [7:0] beat_byte;

    assign in_ready = !skid_valid_reg;
    assign in_take  = in_valid && in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = !out_reg.two_beats || phase_reg;
    assign load_out = !out_valid_reg || (m_tready && m_tlast);

    // Expanded CR/LF: CR on the first beat, LF on the second
    always_comb begin
        if (out_reg.two_beats) begin
            beat_byte = phase_reg ? CH_LF : CH_CR;
        end else begin
            beat_byte = out_reg.rx_byte;
        end
    end

    assign m_tdata = {{(M_TDATA_W - 11){1'b0}}, out_reg.push_dropped, beat_byte,
                      out_reg.rx_valid, out_reg.txd};

    // Output register with a one-entry skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else if (load_out) begin
            phase_reg <= 1'b0;
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (in_take) begin
                out_reg       <= in_res;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else begin
            // advance to the second beat once the first is taken
            if (m_tready) begin
                phase_reg <= 1'b1;
            end
            if (in_take) begin
                skid_reg       <= in_res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule
